// ===== src/brf_pkg.sv =====
`default_nettype none
package brf_pkg;
    localparam int unsigned MAX_LANES = 8;

    typedef enum logic [2:0] {
        FUNC_PUSH  = 3'd0,
        FUNC_POP   = 3'd1,
        FUNC_PEEK  = 3'd2,
        FUNC_CLEAR = 3'd3,
        FUNC_SYNC  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_REJECT   = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_OUT
    } state_t;

    localparam logic [0:0] REG_PATTERN = 1'b0;
    localparam logic [0:0] REG_LENGTH  = 1'b1;
endpackage
`default_nettype wire

// ===== src/brf_in_if.sv =====
`default_nettype none
interface brf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [63:0] data_in;
    logic [3:0]  byte_count;
    modport source (output valid, func, data_in, byte_count, input ready);
    modport sink (input valid, func, data_in, byte_count, output ready);
endinterface
`default_nettype wire

// ===== src/brf_out_if.sv =====
`default_nettype none
interface brf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] data_out;
    logic [3:0]  count_out;
    logic [10:0] fill_level;
    modport source (output valid, status, data_out, count_out, fill_level, input ready);
    modport sink (input valid, status, data_out, count_out, fill_level, output ready);
endinterface
`default_nettype wire

// ===== src/brf_ram.sv =====
`default_nettype none
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/byte_ring_fifo_with_sync_search.sv =====
// Byte ring FIFO with pattern sync.
// Channels: in (func, data_in, byte_count) and out (status, data_out,
// count_out, fill_level), valid/ready each; one result word per input word.
// Config: APB writes to sync_pattern (0x0) and sync_length (0x8).
// Storage is one byte-wide RAM with one write and one registered read port,
// so bytes move one at a time: push or pop/peek of n bytes writes or reads
// them in turn; clear, rejected push and unused codes answer from idle
// without touching the RAM; sync scans up to fill stored bytes, one stored
// byte scanned per cycle.
// An idle block takes the next word once the result register is free or being
// taken in the same cycle; a stalled receiver holds the result and stops input.
// Reset empties the ring at once (pointers and fill go to zero); store
// contents are not cleared and are never read before being written.
// sync_length resets to 1, sync_pattern to zero.
`default_nettype none
module byte_ring_fifo_with_sync_search #(
    parameter int DEPTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    brf_in_if.sink           in_ch,
    brf_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);
    localparam int AW = $clog2(DEPTH);
    localparam int FW = AW + 1;

    brf_pkg::state_t state_reg, state_next;
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [FW-1:0] occ_reg, occ_next;
    logic [63:0]   pat_reg;
    logic [3:0]    len_reg;
    logic [2:0]    func_reg, func_next;
    logic [63:0]   data_reg, data_next;
    logic [3:0]    n_reg, n_next;
    logic [3:0]    i_reg, i_next;     // bytes issued
    logic [3:0]    j_reg, j_next;     // bytes received
    logic [FW-1:0] k_reg, k_next;     // sync: read issue index
    logic [FW-1:0] kr_reg, kr_next;   // sync: bytes examined
    logic [3:0]    hit_reg, hit_next;
    logic          ovalid_reg, ovalid_next;
    logic [1:0]    st_reg, st_next;
    logic [63:0]   dout_reg, dout_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          rvalid_reg, rvalid_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    logic          cfg_wr;
    logic [3:0]    eff_len;
    logic [3:0]    cin;
    logic [7:0]    pb_hit, pb_first;
    logic [3:0]    hit_new;
    logic [FW-1:0] skip;
    logic          out_free;

    brf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        case (paddr[3])
            brf_pkg::REG_PATTERN: prdata = pat_reg;
            default:              prdata = {60'd0, len_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            len_reg <= 4'd1;
        end
        else if (cfg_wr && paddr[2:0] == 3'd0)
        begin
            case (paddr[3])
                brf_pkg::REG_PATTERN: pat_reg <= pwdata;
                default:              len_reg <= pwdata[3:0];
            endcase
        end
    end

    assign eff_len  = (len_reg == 4'd0) ? 4'd1 : ((len_reg > 4'd8) ? 4'd8 : len_reg);
    assign cin      = (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
    assign pb_hit   = pat_reg[{hit_reg[2:0], 3'b000} +: 8];
    assign pb_first = pat_reg[7:0];
    assign hit_new  = (rdata == pb_hit) ? hit_reg + 4'd1 :
                      ((rdata == pb_first) ? 4'd1 : 4'd0);
    assign skip     = kr_reg + FW'(1) - FW'(eff_len);
    assign out_free = !ovalid_reg || out_ch.ready;

    assign in_ch.ready       = (state_reg == brf_pkg::S_IDLE) && out_free;
    assign out_ch.valid      = ovalid_reg;
    assign out_ch.status     = st_reg;
    assign out_ch.data_out   = dout_reg;
    assign out_ch.count_out  = cnt_reg;
    assign out_ch.fill_level = 11'(occ_reg);

    always_comb
    begin
        state_next  = state_reg;
        wp_next = wp_reg; rp_next = rp_reg; occ_next = occ_reg;
        func_next = func_reg; data_next = data_reg; n_next = n_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg; kr_next = kr_reg;
        hit_next = hit_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        st_next = st_reg; dout_next = dout_reg; cnt_next = cnt_reg;
        rvalid_next = 1'b0;
        we = 1'b0; waddr = wp_reg; wdata = data_reg[7:0]; raddr = rp_reg;
        case (state_reg)
            brf_pkg::S_IDLE:
            begin
                if (in_ch.valid && out_free)
                begin
                    func_next = in_ch.func; data_next = in_ch.data_in;
                    i_next = '0; j_next = '0; k_next = '0; kr_next = '0; hit_next = '0;
                    st_next = brf_pkg::ST_DONE; dout_next = '0; cnt_next = '0;
                    case (in_ch.func)
                        brf_pkg::FUNC_PUSH:
                        begin
                            if (FW'(cin) > FW'(DEPTH) - occ_reg)
                            begin
                                st_next = brf_pkg::ST_REJECT;
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                n_next = cin; cnt_next = cin;
                                state_next = brf_pkg::S_READ;
                            end
                        end
                        brf_pkg::FUNC_POP, brf_pkg::FUNC_PEEK:
                        begin
                            n_next = (FW'(cin) > occ_reg) ? 4'(occ_reg) : cin;
                            cnt_next = n_next;
                            state_next = brf_pkg::S_READ;
                        end
                        brf_pkg::FUNC_CLEAR:
                        begin
                            wp_next = '0; rp_next = '0; occ_next = '0;
                            ovalid_next = 1'b1;
                        end
                        brf_pkg::FUNC_SYNC:
                        begin
                            if (FW'(eff_len) > occ_reg)
                            begin
                                st_next = brf_pkg::ST_NOTFOUND;
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = brf_pkg::S_SCAN;
                            end
                        end
                        default: ovalid_next = 1'b1;
                    endcase
                end
            end
            brf_pkg::S_READ:
            begin
                // push writes one byte a cycle; pop/peek reads one a cycle
                if (func_reg == brf_pkg::FUNC_PUSH)
                begin
                    if (i_reg < n_reg)
                    begin
                        we = 1'b1;
                        data_next = data_reg >> 8;
                        wp_next = wp_reg + AW'(1);
                        occ_next = occ_reg + FW'(1);
                        i_next = i_reg + 4'd1;
                    end
                    else
                    begin
                        ovalid_next = 1'b1;
                        state_next = brf_pkg::S_IDLE;
                    end
                end
                else
                begin
                    raddr = rp_reg + AW'(i_reg);
                    if (i_reg < n_reg)
                    begin
                        i_next = i_reg + 4'd1;
                        rvalid_next = 1'b1;
                    end
                    if (rvalid_reg)
                    begin
                        dout_next = dout_reg | (64'(rdata) << {j_reg[2:0], 3'b000});
                        j_next = j_reg + 4'd1;
                    end
                    if (j_next == n_reg && i_reg >= n_reg)
                    begin
                        if (func_reg == brf_pkg::FUNC_POP)
                        begin
                            rp_next = rp_reg + AW'(n_reg);
                            occ_next = occ_reg - FW'(n_reg);
                        end
                        ovalid_next = 1'b1;
                        state_next = brf_pkg::S_IDLE;
                    end
                end
            end
            brf_pkg::S_SCAN:
            begin
                raddr = rp_reg + AW'(k_reg);
                if (k_reg < occ_reg)
                begin
                    k_next = k_reg + FW'(1);
                    rvalid_next = 1'b1;
                end
                if (rvalid_reg)
                begin
                    hit_next = hit_new;
                    kr_next = kr_reg + FW'(1);
                    if (hit_new == eff_len)
                    begin
                        rp_next = rp_reg + AW'(skip);
                        occ_next = occ_reg - skip;
                        ovalid_next = 1'b1;
                        state_next = brf_pkg::S_IDLE;
                    end
                    else if (kr_next == occ_reg)
                    begin
                        st_next = brf_pkg::ST_NOTFOUND;
                        ovalid_next = 1'b1;
                        state_next = brf_pkg::S_IDLE;
                    end
                end
            end
            default: state_next = brf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brf_pkg::S_IDLE;
            wp_reg <= '0; rp_reg <= '0; occ_reg <= '0;
            ovalid_reg <= 1'b0; rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg <= wp_next; rp_reg <= rp_next; occ_reg <= occ_next;
            ovalid_reg <= ovalid_next; rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next; data_reg <= data_next; n_reg <= n_next;
        i_reg <= i_next; j_reg <= j_next; k_reg <= k_next; kr_reg <= kr_next;
        hit_reg <= hit_next;
        st_reg <= st_next; dout_reg <= dout_next; cnt_reg <= cnt_next;
    end
endmodule
`default_nettype wire

// ===== src/brf_checker.sv =====
`default_nettype none
module brf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [3:0]  count_out,
    input wire logic [10:0] fill_level
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped under stall");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_out <= 4'd8)
        else $error("count above eight");
    a_rej: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != brf_pkg::ST_DONE |-> count_out == 4'd0)
        else $error("failed op moved bytes");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fill_level <= 11'd1024)
        else $error("fill above ring size");
endmodule

bind byte_ring_fifo_with_sync_search brf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .status(out_ch.status), .count_out(out_ch.count_out),
    .fill_level(out_ch.fill_level)
);
`default_nettype wire
